@@ design/fpi_pkg.sv @@
// ----------------------------------------------------------------------------
// fpi_pkg
// Shared types and constants of the framebuffer pixel import core: register
// indexes, format and function codes, request and result payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package fpi_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 23;
    localparam int SRC_ADDR_BITS = 23;
    localparam int DEST_BITS     = 20;
    localparam int WIDTH_BITS    = 11;
    localparam int COUNT_BITS    = 10;
    localparam int TOTAL_BITS    = 21;
    localparam int LIMIT_BITS    = 22;
    localparam int BOUND_BITS    = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_ALPHA   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_ADDRESS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_COUNT   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MEMORY_LAST  = 3'd5;

    localparam logic FMT_RGBA5551 = 1'b0;
    localparam logic FMT_RGBA8888 = 1'b1;

    localparam logic FUNC_RASTER = 1'b0;
    localparam logic FUNC_LISTED = 1'b1;

    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX    = 11'd1024;
    localparam logic [COUNT_BITS-1:0] COLUMN_LAST  = 10'd1023;
    localparam logic [7:0]            ALPHA_OPAQUE = 8'hFF;

    localparam logic [WIDTH_BITS-1:0] RST_LINE_WIDTH = 11'd320;
    localparam logic [COUNT_BITS-1:0] RST_LINE_COUNT = 10'd240;
    localparam logic [TOTAL_BITS-1:0] RST_TOTAL      = 21'd76800;
    localparam logic [LIMIT_BITS-1:0] RST_LIMIT      = 22'd77120;

    typedef struct packed {
        logic                     func;
        logic [SRC_ADDR_BITS-1:0] source_address;
        logic [31:0]              source_pixel;
        logic                     first;
        logic                     last;
    } fpi_in_t;

    typedef struct packed {
        logic                 write_valid;
        logic [DEST_BITS-1:0] dest_index;
        logic [31:0]          color;
        logic                 done_res;
        logic                 copy_needed;
        logic                 aborted;
    } fpi_out_t;

    typedef struct packed {
        logic                     is16;
        logic                     full_alpha;
        logic [SRC_ADDR_BITS-1:0] base;
        logic [WIDTH_BITS-1:0]    width_eff;
        logic [TOTAL_BITS-1:0]    total;
        logic [LIMIT_BITS-1:0]    listed_limit;
        logic [BOUND_BITS-1:0]    raster_bound;
    } fpi_cfg_t;

endpackage

`default_nettype wire

@@ design/fpi_stream_if.sv @@
// ----------------------------------------------------------------------------
// fpi_stream_if
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpi_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ design/fpi_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// fpi_cfg_regs
// Configuration registers plus derived limits (clamped width, raster total,
// listed row limit, raster memory bound), updated in the write cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpi_cfg_regs #(
    parameter int ADDR_BITS = 23
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [fpi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [fpi_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output fpi_pkg::fpi_cfg_t                     cfg
);
    import fpi_pkg::*;

    localparam int AEFF = (ADDR_BITS < SRC_ADDR_BITS) ? ADDR_BITS : SRC_ADDR_BITS;
    localparam logic [SRC_ADDR_BITS-1:0] ADDR_MASK =
        {SRC_ADDR_BITS{1'b1}} >> (SRC_ADDR_BITS - AEFF);
    localparam logic [BOUND_BITS-1:0] RST_BOUND = ({1'b0, ADDR_MASK} + 24'd1) >> 1;

    logic                     fmt_reg, fmt_next;
    logic                     fa_reg, fa_next;
    logic [SRC_ADDR_BITS-1:0] base_reg, base_next;
    logic [WIDTH_BITS-1:0]    lw_reg, lw_next;
    logic [COUNT_BITS-1:0]    lc_reg, lc_next;
    logic [SRC_ADDR_BITS-1:0] mlast_reg, mlast_next;
    logic [WIDTH_BITS-1:0]    weff_reg, weff_next;
    logic [TOTAL_BITS-1:0]    total_reg, total_next;
    logic [LIMIT_BITS-1:0]    limit_reg, limit_next;
    logic [BOUND_BITS-1:0]    bound_reg, bound_next;
    logic [BOUND_BITS-1:0]    mem_end;
    logic [BOUND_BITS-1:0]    span;

    always_comb
    begin
        fmt_next   = fmt_reg;
        fa_next    = fa_reg;
        base_next  = base_reg;
        lw_next    = lw_reg;
        lc_next    = lc_reg;
        mlast_next = mlast_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_PIXEL_FORMAT: fmt_next   = cfg_data[0];
                CFG_FULL_ALPHA:   fa_next    = cfg_data[0];
                CFG_BASE_ADDRESS: base_next  = cfg_data & ADDR_MASK;
                CFG_LINE_WIDTH:   lw_next    = cfg_data[WIDTH_BITS-1:0];
                CFG_LINE_COUNT:   lc_next    = cfg_data[COUNT_BITS-1:0];
                CFG_MEMORY_LAST:  mlast_next = cfg_data & ADDR_MASK;
                default: ;
            endcase
        end

        if (lw_next == '0)
        begin
            weff_next = 11'd1;
        end
        else if (lw_next > WIDTH_MAX)
        begin
            weff_next = WIDTH_MAX;
        end
        else
        begin
            weff_next = lw_next;
        end

        total_next = {10'b0, weff_next} * {11'b0, lc_next};
        limit_next = {1'b0, total_next} + {11'b0, weff_next};

        mem_end = {1'b0, mlast_next} + 24'd1;
        if ({1'b0, base_next} <= mem_end)
        begin
            span = mem_end - {1'b0, base_next};
        end
        else
        begin
            span = '0;
        end
        bound_next = (fmt_next == FMT_RGBA5551) ? (span >> 1) : (span >> 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_RGBA5551;
            fa_reg    <= 1'b0;
            base_reg  <= '0;
            lw_reg    <= RST_LINE_WIDTH;
            lc_reg    <= RST_LINE_COUNT;
            mlast_reg <= ADDR_MASK;
            weff_reg  <= RST_LINE_WIDTH;
            total_reg <= RST_TOTAL;
            limit_reg <= RST_LIMIT;
            bound_reg <= RST_BOUND;
        end
        else
        begin
            fmt_reg   <= fmt_next;
            fa_reg    <= fa_next;
            base_reg  <= base_next;
            lw_reg    <= lw_next;
            lc_reg    <= lc_next;
            mlast_reg <= mlast_next;
            weff_reg  <= weff_next;
            total_reg <= total_next;
            limit_reg <= limit_next;
            bound_reg <= bound_next;
        end
    end

    assign cfg.is16         = (fmt_reg == FMT_RGBA5551);
    assign cfg.full_alpha   = fa_reg;
    assign cfg.base         = base_reg;
    assign cfg.width_eff    = weff_reg;
    assign cfg.total        = total_reg;
    assign cfg.listed_limit = limit_reg;
    assign cfg.raster_bound = bound_reg;

endmodule

`default_nettype wire

@@ design/fpi_convert.sv @@
// ----------------------------------------------------------------------------
// fpi_convert
// Pixel format conversion: RGBA5551 or RGBA8888 to ABGR8888.
// ----------------------------------------------------------------------------
`default_nettype none

module fpi_convert (
    input  wire logic        is16,
    input  wire logic        full_alpha,
    input  wire logic [31:0] pixel,
    output logic      [31:0] color
);
    import fpi_pkg::*;

    logic [7:0] r, g, b, a;

    always_comb
    begin
        if (is16)
        begin
            r = {pixel[15:11], 3'b000};
            g = {pixel[10:6], 3'b000};
            b = {pixel[5:1], 3'b000};
            a = (full_alpha || pixel[0]) ? ALPHA_OPAQUE : 8'h00;
        end
        else
        begin
            r = pixel[31:24];
            g = pixel[23:16];
            b = pixel[15:8];
            a = full_alpha ? ALPHA_OPAQUE : pixel[7:0];
        end
        color = {a, b, g, r};
    end

endmodule

`default_nettype wire

@@ design/framebuffer_pixel_import_core.sv @@
// ----------------------------------------------------------------------------
// framebuffer_pixel_import_core
// Framebuffer pixel import: converts pixels to ABGR8888, assigns destination
// indexes in raster or listed mode, tracks the source sum and abort status.
// ----------------------------------------------------------------------------
// One request is taken per cycle while the result side keeps taking. An accepted
// request is held in the request register, which feeds the per-pixel conversion,
// compare and sum logic that loads the result register presenting the result.
// Throughput is one pixel per clock while the result side keeps taking; a stalled
// result holds one request in the request register. Configuration writes take
// effect, once registered, for the request then held in the request register.
`default_nettype none

module framebuffer_pixel_import_core #(
    parameter int ADDR_BITS  = 23,
    parameter int INDEX_BITS = 20
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [fpi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [fpi_pkg::CFG_DATA_BITS-1:0] cfg_data,
    fpi_stream_if.sink                            pixels,
    fpi_stream_if.source                          results
);
    import fpi_pkg::*;

    localparam int AEFF = (ADDR_BITS < SRC_ADDR_BITS) ? ADDR_BITS : SRC_ADDR_BITS;
    localparam logic [SRC_ADDR_BITS-1:0] ADDR_MASK =
        {SRC_ADDR_BITS{1'b1}} >> (SRC_ADDR_BITS - AEFF);
    localparam int IEFF = (INDEX_BITS < SRC_ADDR_BITS) ? INDEX_BITS : SRC_ADDR_BITS;
    localparam logic [SRC_ADDR_BITS-1:0] INDEX_MASK =
        {SRC_ADDR_BITS{1'b1}} >> (SRC_ADDR_BITS - IEFF);
    localparam int CW = ((INDEX_BITS > BOUND_BITS) ? INDEX_BITS : BOUND_BITS) + 1;

    fpi_cfg_t cfg;

    fpi_cfg_regs #(
        .ADDR_BITS (ADDR_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic     s1_valid_reg, s1_valid_next;
    fpi_in_t  s1_data_reg;
    logic     out_valid_reg, out_valid_next;
    fpi_out_t out_data_reg, out_data_next;
    logic     take, advance;

    logic [INDEX_BITS-1:0] pc_reg, pc_next, pc_c;
    logic [COUNT_BITS-1:0] col_reg, col_next, col_c;
    logic                  rs_reg, rs_next, rs_c;
    logic [31:0]           sum_reg, sum_next, sum_c;
    logic                  abort_reg, abort_next, abort_c;

    logic [31:0]                 src_val;
    logic [31:0]                 conv_color;
    logic [INDEX_BITS-1:0]       raster_idx;
    logic [CW-1:0]               pc_ext, idx_ext, total_ext, bound_ext;
    logic                        in_rows, stop_now, row_wrap;
    logic [INDEX_BITS+DEST_BITS-1:0] pc_wide;
    logic [SRC_ADDR_BITS-1:0]    addr_m, addr_diff, listed_idx, listed_dest;
    logic                        addr_low, row_bad;
    logic                        wv;
    logic [DEST_BITS-1:0]        dest;

    assign advance      = s1_valid_reg && (!out_valid_reg || results.ready);
    assign pixels.ready = !s1_valid_reg || advance;
    assign take         = pixels.valid && pixels.ready;

    fpi_convert u_convert (
        .is16       (cfg.is16),
        .full_alpha (cfg.full_alpha),
        .pixel      (s1_data_reg.source_pixel),
        .color      (conv_color)
    );

    always_comb
    begin
        if (s1_data_reg.first)
        begin
            pc_c    = '0;
            col_c   = '0;
            rs_c    = 1'b0;
            sum_c   = '0;
            abort_c = 1'b0;
        end
        else
        begin
            pc_c    = pc_reg;
            col_c   = col_reg;
            rs_c    = rs_reg;
            sum_c   = sum_reg;
            abort_c = abort_reg;
        end

        src_val = cfg.is16 ? {16'b0, s1_data_reg.source_pixel[15:0]}
                           : s1_data_reg.source_pixel;

        raster_idx = pc_c ^ {{(INDEX_BITS-1){1'b0}}, cfg.is16};
        pc_ext     = {{(CW-INDEX_BITS){1'b0}}, pc_c};
        idx_ext    = {{(CW-INDEX_BITS){1'b0}}, raster_idx};
        total_ext  = {{(CW-TOTAL_BITS){1'b0}}, cfg.total};
        bound_ext  = {{(CW-BOUND_BITS){1'b0}}, cfg.raster_bound};
        in_rows    = pc_ext < total_ext;
        stop_now   = rs_c || (idx_ext >= bound_ext);
        row_wrap   = (({1'b0, col_c} + 11'd1) >= cfg.width_eff) || (col_c == COLUMN_LAST);
        pc_wide    = {{DEST_BITS{1'b0}}, pc_c};

        addr_m      = s1_data_reg.source_address & ADDR_MASK;
        addr_low    = addr_m < cfg.base;
        addr_diff   = addr_m - cfg.base;
        listed_idx  = cfg.is16 ? (addr_diff >> 1) : (addr_diff >> 2);
        row_bad     = listed_idx >= {1'b0, cfg.listed_limit};
        listed_dest = (listed_idx ^ {{(SRC_ADDR_BITS-1){1'b0}}, cfg.is16}) & INDEX_MASK;

        pc_next    = pc_c;
        col_next   = col_c;
        rs_next    = rs_c;
        abort_next = abort_c;
        wv         = 1'b0;
        dest       = '0;

        if (!abort_c)
        begin
            if (s1_data_reg.func == FUNC_RASTER)
            begin
                if (in_rows)
                begin
                    if (!stop_now)
                    begin
                        wv   = 1'b1;
                        dest = pc_wide[DEST_BITS-1:0];
                    end
                    if (row_wrap)
                    begin
                        col_next = '0;
                        rs_next  = 1'b0;
                    end
                    else
                    begin
                        col_next = col_c + 10'd1;
                        rs_next  = stop_now;
                    end
                    pc_next = pc_c + {{(INDEX_BITS-1){1'b0}}, 1'b1};
                end
            end
            else
            begin
                if (addr_low || row_bad)
                begin
                    abort_next = 1'b1;
                end
                else
                begin
                    wv   = 1'b1;
                    dest = listed_dest[DEST_BITS-1:0];
                end
            end
        end

        sum_next = wv ? (sum_c + src_val) : sum_c;

        out_data_next.write_valid = wv;
        out_data_next.dest_index  = dest;
        out_data_next.color       = wv ? conv_color : 32'd0;
        out_data_next.done_res    = s1_data_reg.last;
        out_data_next.copy_needed = s1_data_reg.last && !abort_next && (sum_next != 32'd0);
        out_data_next.aborted     = abort_next;

        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            col_reg       <= '0;
            rs_reg        <= 1'b0;
            sum_reg       <= '0;
            abort_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pc_reg    <= pc_next;
                col_reg   <= col_next;
                rs_reg    <= rs_next;
                sum_reg   <= sum_next;
                abort_reg <= abort_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_data_reg <= pixels.data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    a_stall_holds_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("request dropped while result stalled");

    a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixels.ready |-> (s1_valid_reg && results.valid && !results.ready))
        else $error("request side stalled without a full pipeline");

    a_abort_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (abort_reg && !(advance && s1_data_reg.first)) |=> abort_reg)
        else $error("abort cleared without a first request");

    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(s1_valid_reg))
        else $error("result raised without a request");

    a_no_write_when_aborted: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && abort_next) |=> !results.data.write_valid)
        else $error("aborted request produced a write");

endmodule

`default_nettype wire
